// File: rtl/rrts_pkg.sv
// Package: shared types and constants of the round robin task scheduler.
`default_nettype none
package rrts_pkg;

   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int IDENT_W   = 16;
   localparam int SLOT_W    = 4;
   localparam int LIVE_W    = 5;
   localparam int CNT_W     = 32;
   localparam int WORD_W    = 64;
   localparam int SLEEP_W   = 32;
   localparam int CSR_IDX_W = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SCHEDULE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE_KERN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CREATE_USER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SLEEP       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EXIT        = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_SLOT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_IDS  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_EN   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_STACK = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_START = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_STACK = 8'd3;

   typedef enum logic [2:0] {
      SLOT_FREE     = 3'd0,
      SLOT_READY    = 3'd1,
      SLOT_RUNNING  = 3'd2,
      SLOT_SLEEPING = 3'd3,
      SLOT_DEAD     = 3'd4
   } slot_state_type;

   // one task table entry
   typedef struct packed {
      slot_state_type       state;
      logic [IDENT_W-1:0]   ident;
      logic [IDENT_W-1:0]   parent;
      logic                 ring;
      logic [WORD_W-1:0]    wake;
      logic [WORD_W-1:0]    context_ptr;
      logic [WORD_W-1:0]    kstack;
   } slot_word_type;

   typedef struct packed {
      logic                 sched_en;
      logic [WORD_W-1:0]    idle_stack_top;
      logic [WORD_W-1:0]    idle_start_context;
      logic [WORD_W-1:0]    main_stack_top;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IDENT_W-1:0]   task_ident;
      logic [SLOT_W-1:0]    chosen_slot;
      logic [WORD_W-1:0]    resume_context;
      logic [WORD_W-1:0]    resume_stack_top;
      logic                 went_idle;
      logic                 switched;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/rrts_intf.sv
// Interfaces: request, response and configuration channels.
`default_nettype none
interface rrts_req_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::CMD_W-1:0]        command;
   logic [rrts_pkg::WORD_W-1:0]       now_ms;
   logic [rrts_pkg::WORD_W-1:0]       saved_context;
   logic [rrts_pkg::SLEEP_W-1:0]      sleep_length;
   logic [rrts_pkg::WORD_W-1:0]       initial_context;
   logic [rrts_pkg::WORD_W-1:0]       new_stack_top;
   modport source (output valid, command, now_ms, saved_context, sleep_length,
                   initial_context, new_stack_top, input ready);
   modport sink (input valid, command, now_ms, saved_context, sleep_length,
                 initial_context, new_stack_top, output ready);
endinterface

interface rrts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::STATUS_W-1:0]     status;
   logic [rrts_pkg::IDENT_W-1:0]      task_ident;
   logic [rrts_pkg::SLOT_W-1:0]       chosen_slot;
   logic [rrts_pkg::WORD_W-1:0]       resume_context;
   logic [rrts_pkg::WORD_W-1:0]       resume_stack_top;
   logic                              went_idle;
   logic                              switched;
   logic [rrts_pkg::LIVE_W-1:0]       live_tasks;
   logic [rrts_pkg::CNT_W-1:0]        schedule_count;
   logic [rrts_pkg::CNT_W-1:0]        switch_count;
   modport source (output valid, status, task_ident, chosen_slot, resume_context,
                   resume_stack_top, went_idle, switched, live_tasks,
                   schedule_count, switch_count, input ready);
   modport sink (input valid, status, task_ident, chosen_slot, resume_context,
                 resume_stack_top, went_idle, switched, live_tasks,
                 schedule_count, switch_count, output ready);
endinterface

interface rrts_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::CSR_IDX_W-1:0]    index;
   logic [rrts_pkg::WORD_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/round_robin_task_scheduler_top.sv
// Top level: round robin task scheduler sequencer around the task table RAM.
//
//   channel   dir  handshake     beat carries
//   req_chan  in   valid/ready   command, now_ms, saved_context, sleep_length,
//                                initial_context, new_stack_top
//   rsp_chan  out  valid/ready   status, ident, slot, resume context/stack, flags,
//                                live count, schedule and switch counters
//   csr_chan  in   valid/ready   register index, 64-bit write data (always ready)
//
// Sequence: create, sleep, exit and disabled schedule pass S_IDLE, S_MOD, S_DONE;
// an enabled schedule adds S_SCAN and S_COMMIT, with a one-entry-per-cycle
// scan of the task table RAM (one read and one write port).
// Reset: synchronous; the table reads as slot 0 running, rest free, through
// per-slot valid bits, so no clearing pass is needed.
// Stalls: one beat is worked at a time; a held response parks the sequencer
// in its last state until rsp_chan takes it.
`default_nettype none
module round_robin_task_scheduler_top #(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   rrts_req_if.sink   req_chan,
   rrts_rsp_if.source rsp_chan,
   rrts_csr_if.sink   csr_chan
);
   localparam int IW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MOD    = 6'b000010,
      S_SCAN   = 6'b000100,
      S_COMMIT = 6'b001000,
      S_DONE   = 6'b010000,
      S_SPARE  = 6'b100000
   } fsm_type;

   rrts_pkg::cfg_type cfg;

   rrts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // task table
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   rrts_pkg::slot_word_type wr_word;
   logic                    rd_en;
   logic [IW-1:0]           rd_addr;
   rrts_pkg::slot_word_type ram_q;

   rrts_ram #(
      .WIDTH ($bits(rrts_pkg::slot_word_type)),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   fsm_type                         state_ff, state_in;
   logic [rrts_pkg::CMD_W-1:0]      cmd_ff;
   logic [rrts_pkg::WORD_W-1:0]     now_ff, saved_ff, init_ctx_ff, new_stk_ff;
   logic [rrts_pkg::SLEEP_W-1:0]    sleep_ff;
   logic [IW-1:0]                   run_slot_ff, run_slot_in;
   logic                            run_idle_ff, run_idle_in;
   logic [rrts_pkg::IDENT_W-1:0]    next_id_ff, next_id_in;
   logic [rrts_pkg::WORD_W-1:0]     idle_ctx_ff, idle_ctx_in;
   logic                            idle_saved_ff, idle_saved_in;
   logic [rrts_pkg::CNT_W-1:0]      sched_cnt_ff, sched_cnt_in;
   logic [rrts_pkg::CNT_W-1:0]      sw_cnt_ff, sw_cnt_in;
   logic [CW-1:0]                   live_ff, live_in;
   logic [TASK_SLOTS-1:0]           valid_ff, valid_in;
   logic                            rd_valid_ff;
   logic [IW-1:0]                   daddr_ff, daddr_in;
   logic [IW-1:0]                   raddr_ff, raddr_in;
   logic [CW-1:0]                   issue_ff, issue_in;
   logic                            dpend_ff, dpend_in;
   logic                            found_ff, found_in;
   logic [IW-1:0]                   pick_ff, pick_in;
   rrts_pkg::slot_word_type         pick_word_ff, pick_word_in;
   rrts_pkg::result_type            res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rrts_pkg::result_type            rsp_ff, rsp_in;
   logic [CW-1:0]                   rsp_live_ff, rsp_live_in;
   logic [rrts_pkg::CNT_W-1:0]      rsp_sched_ff, rsp_sched_in;
   logic [rrts_pkg::CNT_W-1:0]      rsp_sw_ff, rsp_sw_in;

   // entry seen at the read port; never-written slots show their reset value
   rrts_pkg::slot_word_type eff_word;
   always_comb begin
      if (rd_valid_ff) begin
         eff_word = ram_q;
      end else begin
         eff_word       = '0;
         eff_word.state = (daddr_ff == '0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_FREE;
      end
   end

   function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
      return (s == IW'(TASK_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   logic req_fire;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      rrts_pkg::slot_word_type w;
      rrts_pkg::slot_state_type st;
      logic [IW-1:0] start;
      logic          deliver;

      state_in      = state_ff;
      run_slot_in   = run_slot_ff;
      run_idle_in   = run_idle_ff;
      next_id_in    = next_id_ff;
      idle_ctx_in   = idle_ctx_ff;
      idle_saved_in = idle_saved_ff;
      sched_cnt_in  = sched_cnt_ff;
      sw_cnt_in     = sw_cnt_ff;
      live_in       = live_ff;
      valid_in      = valid_ff;
      daddr_in      = daddr_ff;
      raddr_in      = raddr_ff;
      issue_in      = issue_ff;
      dpend_in      = 1'b0;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_word_in  = pick_word_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_sched_in  = rsp_sched_ff;
      rsp_sw_in     = rsp_sw_ff;
      wr_en         = 1'b0;
      wr_addr       = run_slot_ff;
      wr_word       = eff_word;
      rd_en         = 1'b0;
      rd_addr       = run_slot_ff;
      w             = eff_word;
      st            = eff_word.state;
      start         = run_idle_ff ? '0 : run_slot_ff;
      deliver       = !rsp_valid_ff || rsp_chan.ready;

      case (state_ff)
         S_IDLE: begin
            // fetch the running entry while the beat is latched
            if (req_fire) begin
               rd_en    = 1'b1;
               daddr_in = run_slot_ff;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            res_in   = '0;
            state_in = S_DONE;
            case (cmd_ff)
               rrts_pkg::CMD_SCHEDULE: begin
                  if (!cfg.sched_en) begin
                     res_in.resume_context = saved_ff;
                  end else begin
                     sched_cnt_in = sched_cnt_ff + 1'b1;
                     if (!run_idle_ff) begin
                        w.context_ptr = saved_ff;
                        if (w.state == rrts_pkg::SLOT_RUNNING) begin
                           w.state = rrts_pkg::SLOT_READY;
                        end
                        wr_en   = 1'b1;
                        wr_addr = run_slot_ff;
                        wr_word = w;
                     end else begin
                        idle_ctx_in   = saved_ff;
                        idle_saved_in = 1'b1;
                     end
                     raddr_in = slot_inc(start);
                     issue_in = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               rrts_pkg::CMD_CREATE_KERN, rrts_pkg::CMD_CREATE_USER: begin
                  // slots are never freed, so the first free slot is the live count
                  if (live_ff == CW'(TASK_SLOTS)) begin
                     res_in.status = rrts_pkg::STAT_NO_SLOT;
                  end else if (next_id_ff == '0) begin
                     res_in.status = rrts_pkg::STAT_NO_IDS;
                  end else begin
                     wr_word.state       = rrts_pkg::SLOT_READY;
                     wr_word.ident       = next_id_ff;
                     wr_word.parent      = run_idle_ff ? '0 : eff_word.ident;
                     wr_word.ring        = (cmd_ff == rrts_pkg::CMD_CREATE_USER);
                     wr_word.wake        = '0;
                     wr_word.context_ptr = init_ctx_ff;
                     wr_word.kstack      = new_stk_ff;
                     wr_en               = 1'b1;
                     wr_addr             = live_ff[IW-1:0];
                     next_id_in          = next_id_ff + 1'b1;
                     live_in             = live_ff + 1'b1;
                     res_in.task_ident   = next_id_ff;
                     res_in.chosen_slot  = rrts_pkg::SLOT_W'(live_ff);
                  end
               end
               rrts_pkg::CMD_SLEEP: begin
                  if (!cfg.sched_en || run_idle_ff) begin
                     res_in.status = rrts_pkg::STAT_IGNORED;
                  end else begin
                     w.wake  = now_ff + rrts_pkg::WORD_W'(sleep_ff);
                     w.state = rrts_pkg::SLOT_SLEEPING;
                     wr_en   = 1'b1;
                     wr_word = w;
                  end
               end
               rrts_pkg::CMD_EXIT: begin
                  if (run_idle_ff || run_slot_ff == '0) begin
                     res_in.status = rrts_pkg::STAT_IGNORED;
                  end else begin
                     w.state = rrts_pkg::SLOT_DEAD;
                     wr_en   = 1'b1;
                     wr_word = w;
                  end
               end
               default: res_in.status = rrts_pkg::STAT_IGNORED;
            endcase
         end
         S_SCAN: begin
            // issue one read per cycle in round robin order, running slot last
            if (issue_ff != CW'(TASK_SLOTS)) begin
               rd_en    = 1'b1;
               rd_addr  = raddr_ff;
               daddr_in = raddr_ff;
               raddr_in = slot_inc(raddr_ff);
               issue_in = issue_ff + 1'b1;
               dpend_in = 1'b1;
            end
            // wake sleepers and note the first ready slot
            if (dpend_ff) begin
               if (st == rrts_pkg::SLOT_SLEEPING && now_ff >= eff_word.wake) begin
                  st      = rrts_pkg::SLOT_READY;
                  w.state = rrts_pkg::SLOT_READY;
                  wr_en   = 1'b1;
                  wr_addr = daddr_ff;
                  wr_word = w;
               end
               if (st == rrts_pkg::SLOT_READY && !found_ff) begin
                  found_in     = 1'b1;
                  pick_in      = daddr_ff;
                  pick_word_in = w;
               end
            end else if (issue_ff == CW'(TASK_SLOTS)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            state_in = S_DONE;
            if (found_ff) begin
               w         = pick_word_ff;
               w.state   = rrts_pkg::SLOT_RUNNING;
               wr_en     = 1'b1;
               wr_addr   = pick_ff;
               wr_word   = w;
               if (run_idle_ff || pick_ff != run_slot_ff) begin
                  sw_cnt_in       = sw_cnt_ff + 1'b1;
                  res_in.switched = 1'b1;
               end
               run_slot_in             = pick_ff;
               run_idle_in             = 1'b0;
               res_in.task_ident       = pick_word_ff.ident;
               res_in.chosen_slot      = rrts_pkg::SLOT_W'(pick_ff);
               res_in.resume_context   = pick_word_ff.context_ptr;
               res_in.resume_stack_top = (pick_ff == '0) ? cfg.main_stack_top
                                                         : pick_word_ff.kstack;
            end else begin
               run_idle_in             = 1'b1;
               run_slot_in             = '0;
               res_in.went_idle        = 1'b1;
               res_in.resume_context   = idle_saved_ff ? idle_ctx_ff
                                                       : cfg.idle_start_context;
               res_in.resume_stack_top = cfg.idle_stack_top;
            end
         end
         S_DONE: begin
            if (deliver) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_live_in  = live_ff;
               rsp_sched_in = sched_cnt_ff;
               rsp_sw_in    = sw_cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_slot_ff   <= '0;
         run_idle_ff   <= 1'b0;
         next_id_ff    <= rrts_pkg::IDENT_W'(1);
         idle_ctx_ff   <= '0;
         idle_saved_ff <= 1'b0;
         sched_cnt_ff  <= '0;
         sw_cnt_ff     <= '0;
         live_ff       <= CW'(1);
         valid_ff      <= '0;
         dpend_ff      <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_slot_ff   <= run_slot_in;
         run_idle_ff   <= run_idle_in;
         next_id_ff    <= next_id_in;
         idle_ctx_ff   <= idle_ctx_in;
         idle_saved_ff <= idle_saved_in;
         sched_cnt_ff  <= sched_cnt_in;
         sw_cnt_ff     <= sw_cnt_in;
         live_ff       <= live_in;
         valid_ff      <= valid_in;
         dpend_ff      <= dpend_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff      <= req_chan.command;
         now_ff      <= req_chan.now_ms;
         saved_ff    <= req_chan.saved_context;
         sleep_ff    <= req_chan.sleep_length;
         init_ctx_ff <= req_chan.initial_context;
         new_stk_ff  <= req_chan.new_stack_top;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      daddr_ff     <= daddr_in;
      raddr_ff     <= raddr_in;
      issue_ff     <= issue_in;
      pick_ff      <= pick_in;
      pick_word_ff <= pick_word_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rsp_live_ff  <= rsp_live_in;
      rsp_sched_ff <= rsp_sched_in;
      rsp_sw_ff    <= rsp_sw_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_ff.status;
   assign rsp_chan.task_ident       = rsp_ff.task_ident;
   assign rsp_chan.chosen_slot      = rsp_ff.chosen_slot;
   assign rsp_chan.resume_context   = rsp_ff.resume_context;
   assign rsp_chan.resume_stack_top = rsp_ff.resume_stack_top;
   assign rsp_chan.went_idle        = rsp_ff.went_idle;
   assign rsp_chan.switched         = rsp_ff.switched;
   assign rsp_chan.live_tasks       = rrts_pkg::LIVE_W'(rsp_live_ff);
   assign rsp_chan.schedule_count   = rsp_sched_ff;
   assign rsp_chan.switch_count     = rsp_sw_ff;
endmodule
`default_nettype wire

// File: rtl/rrts_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/rrts_csr.sv
// Configuration register bank.
`default_nettype none
module rrts_csr (
   input  wire logic      clock,
   input  wire logic      reset,
   rrts_csr_if.sink       csr_chan,
   output rrts_pkg::cfg_type cfg
);
   rrts_pkg::cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sched_en           <= 1'b1;
         cfg_ff.idle_stack_top     <= '0;
         cfg_ff.idle_start_context <= '0;
         cfg_ff.main_stack_top     <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            rrts_pkg::CSR_SCHED_EN:   cfg_ff.sched_en           <= csr_chan.data[0];
            rrts_pkg::CSR_IDLE_STACK: cfg_ff.idle_stack_top     <= csr_chan.data;
            rrts_pkg::CSR_IDLE_START: cfg_ff.idle_start_context <= csr_chan.data;
            rrts_pkg::CSR_MAIN_STACK: cfg_ff.main_stack_top     <= csr_chan.data;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
